>>> design/dnc_pkg.sv
// Shared types, constants and calendar tables for the date/time converter.
package dnc_pkg;

    // Field widths of the clamped date and time
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int WK_W    = 3;
    localparam int TOTAL_W = 32;

    // Internal widths
    localparam int QY_W   = 10;   // year / 100, at most 655
    localparam int Q100_W = 10;   // (n + 99) / 100, at most 656
    localparam int Q400_W = 8;    // (n + 399) / 400, at most 164
    localparam int QSUM_W = 15;   // leap days of the whole years
    localparam int YY_W   = 7;    // year mod 100
    localparam int DAYS_W = 25;   // day count from year zero
    localparam int TOD_W  = 17;   // seconds within the day
    localparam int WSUM_W = 8;    // weekday sum before mod 7
    localparam int RECIP_W = 17;
    localparam int PROD_W  = 34;

    localparam int NUM_STAGES = 5;

    // Reciprocal for division by 100 (shift 23) and by 400 (shift 25);
    // exact for dividends below 91180.
    localparam logic [RECIP_W-1:0] RECIP_100 = 17'd83887;
    localparam int SHIFT_100 = 23;
    localparam int SHIFT_400 = 25;

    localparam logic [YEAR_W-1:0]  YEAR_BIAS_100 = 16'd99;
    localparam logic [YEAR_W:0]    YEAR_BIAS_400 = 17'd399;
    localparam logic [DAYS_W-1:0]  DAYS_PER_YEAR = 25'd365;
    localparam logic [RECIP_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [TOD_W-1:0]   SECS_PER_HOUR = 17'd3600;
    localparam logic [TOD_W-1:0]   SECS_PER_MIN  = 17'd60;

    localparam logic [DAY_W-1:0]   DAY_MAX   = 5'd31;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
    localparam logic [MIN_W-1:0]   MIN_MAX   = 6'd59;
    localparam logic [SEC_W-1:0]   SEC_MAX   = 6'd59;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_dt;

    typedef struct packed {
        t_dt               dt;
        logic [YEAR_W-1:0] n;
        logic [QY_W-1:0]   qy;
        logic [Q100_W-1:0] q100;
        logic [Q400_W-1:0] q400;
    } t_s1;

    typedef struct packed {
        t_dt               dt;
        logic [YY_W-1:0]   yy;
        logic [1:0]        qy_lo;
        logic [DAYS_W-1:0] n365;
        logic [QSUM_W-1:0] qsum;
        logic [TOD_W-1:0]  tod;
    } t_s2;

    typedef struct packed {
        t_dt               dt;
        logic [DAYS_W-1:0] days;
        logic [WSUM_W-1:0] wsum;
        logic [TOD_W-1:0]  tod;
    } t_s3;

    typedef struct packed {
        t_dt                dt;
        logic [TOTAL_W-1:0] prod;
        logic [WK_W-1:0]    wk;
        logic [TOD_W-1:0]   tod;
    } t_s4;

    typedef struct packed {
        t_dt                dt;
        logic [WK_W-1:0]    wk;
        logic [TOTAL_W-1:0] total;
    } t_s5;

    // Month length for clamping; February is handled by the caller
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB:                                  len = 5'd28;
            default:                                    len = 5'd31;
        endcase
        return len;
    endfunction

    // Weekday month code
    function automatic logic [WK_W-1:0] month_code(input logic [MONTH_W-1:0] m);
        logic [WK_W-1:0] code;
        unique case (m)
            MONTH_JAN: code = 3'd6;
            MONTH_FEB: code = 3'd2;
            MONTH_MAR: code = 3'd2;
            MONTH_APR: code = 3'd5;
            MONTH_MAY: code = 3'd0;
            MONTH_JUN: code = 3'd3;
            MONTH_JUL: code = 3'd5;
            MONTH_AUG: code = 3'd1;
            MONTH_SEP: code = 3'd4;
            MONTH_OCT: code = 3'd6;
            MONTH_NOV: code = 3'd2;
            default:   code = 3'd4;
        endcase
        return code;
    endfunction

    // Days of the months before m in a common year
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        unique case (m)
            MONTH_FEB: d = 9'd31;
            MONTH_MAR: d = 9'd59;
            MONTH_APR: d = 9'd90;
            MONTH_MAY: d = 9'd120;
            MONTH_JUN: d = 9'd151;
            MONTH_JUL: d = 9'd181;
            MONTH_AUG: d = 9'd212;
            MONTH_SEP: d = 9'd243;
            MONTH_OCT: d = 9'd273;
            MONTH_NOV: d = 9'd304;
            MONTH_DEC: d = 9'd334;
            default:   d = 9'd0;
        endcase
        return d;
    endfunction

    // Residue mod 7 by folding powers of eight (both 64 and 8 are 1 mod 7)
    function automatic logic [WK_W-1:0] mod7(input logic [WSUM_W-1:0] v);
        logic [6:0] a;
        logic [3:0] b;
        logic [3:0] c;
        a = 7'(v[7:6]) + 7'(v[5:0]);
        b = 4'(a[6:3]) + 4'(a[2:0]);
        c = 4'(b[3]) + 4'(b[2:0]);
        if (c >= 4'd7) begin
            c = c - 4'd7;
        end
        return c[WK_W-1:0];
    endfunction

endpackage

>>> design/dnc_clamp.sv
// First stage: field clamping and reciprocal quotients of the year.
module dnc_clamp (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [7:0]                  i_raw_day,
    input  logic [7:0]                  i_raw_month,
    input  logic [dnc_pkg::YEAR_W-1:0]  i_raw_year,
    input  logic [7:0]                  i_raw_hour,
    input  logic [7:0]                  i_raw_minute,
    input  logic [7:0]                  i_raw_second,
    output dnc_pkg::t_s1                o_s1
);

    dnc_pkg::t_s1                    r_s1;
    dnc_pkg::t_s1                    n_s1;
    logic [dnc_pkg::DAY_W-1:0]       day_c;
    logic [dnc_pkg::DAY_W-1:0]       lim;
    logic [dnc_pkg::MONTH_W-1:0]     mon_c;
    logic [dnc_pkg::YEAR_W-1:0]      n_yr;
    logic [dnc_pkg::YEAR_W:0]        a100;
    logic [dnc_pkg::YEAR_W:0]        a400;
    logic [dnc_pkg::PROD_W-1:0]      p_y;
    logic [dnc_pkg::PROD_W-1:0]      p_100;
    logic [dnc_pkg::PROD_W-1:0]      p_400;

    always_comb begin
        if (i_raw_day == 8'd0) begin
            day_c = 5'd1;
        end else if (i_raw_day > 8'(dnc_pkg::DAY_MAX)) begin
            day_c = dnc_pkg::DAY_MAX;
        end else begin
            day_c = i_raw_day[dnc_pkg::DAY_W-1:0];
        end

        if (i_raw_month == 8'd0) begin
            mon_c = dnc_pkg::MONTH_JAN;
        end else if (i_raw_month > 8'(dnc_pkg::MONTH_MAX)) begin
            mon_c = dnc_pkg::MONTH_MAX;
        end else begin
            mon_c = i_raw_month[dnc_pkg::MONTH_W-1:0];
        end

        // February by the plain every-fourth-year rule
        if (mon_c == dnc_pkg::MONTH_FEB) begin
            lim = (i_raw_year[1:0] == 2'd0) ? 5'd29 : 5'd28;
        end else begin
            lim = dnc_pkg::month_len(mon_c);
        end

        n_yr  = (i_raw_year == '0) ? '0 : i_raw_year - 16'd1;
        a100  = 17'(n_yr) + 17'(dnc_pkg::YEAR_BIAS_100);
        a400  = 17'(n_yr) + dnc_pkg::YEAR_BIAS_400;
        p_y   = 34'(i_raw_year) * 34'(dnc_pkg::RECIP_100);
        p_100 = 34'(a100) * 34'(dnc_pkg::RECIP_100);
        p_400 = 34'(a400) * 34'(dnc_pkg::RECIP_100);

        n_s1.dt.day    = (day_c > lim) ? lim : day_c;
        n_s1.dt.month  = mon_c;
        n_s1.dt.year   = i_raw_year;
        n_s1.dt.hour   = (i_raw_hour > 8'(dnc_pkg::HOUR_MAX)) ? dnc_pkg::HOUR_MAX
                                                              : i_raw_hour[4:0];
        n_s1.dt.minute = (i_raw_minute > 8'(dnc_pkg::MIN_MAX)) ? dnc_pkg::MIN_MAX
                                                               : i_raw_minute[5:0];
        n_s1.dt.second = (i_raw_second > 8'(dnc_pkg::SEC_MAX)) ? dnc_pkg::SEC_MAX
                                                               : i_raw_second[5:0];
        n_s1.n    = n_yr;
        n_s1.qy   = p_y[dnc_pkg::SHIFT_100 +: dnc_pkg::QY_W];
        n_s1.q100 = p_100[dnc_pkg::SHIFT_100 +: dnc_pkg::Q100_W];
        n_s1.q400 = p_400[dnc_pkg::SHIFT_400 +: dnc_pkg::Q400_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

>>> design/dnc_days.sv
// Second and third stages: year remainder, whole-year days, day count, weekday sum.
module dnc_days (
    input  logic          i_clk,
    input  logic [1:0]    i_en,
    input  dnc_pkg::t_s1  i_s1,
    output dnc_pkg::t_s3  o_s3
);

    dnc_pkg::t_s2                    r_s2;
    dnc_pkg::t_s2                    n_s2;
    dnc_pkg::t_s3                    r_s3;
    dnc_pkg::t_s3                    n_s3;
    logic [dnc_pkg::YEAR_W-1:0]      yr_mod;
    logic [dnc_pkg::YEAR_W:0]        q4;
    logic [dnc_pkg::YEAR_W:0]        qsum;
    logic                            y4;
    logic                            leap;
    logic                            early;

    // Stage two
    always_comb begin
        yr_mod = i_s1.dt.year - 16'(17'(i_s1.qy) * 17'd100);
        q4     = (17'(i_s1.n) + 17'd3) >> 2;
        qsum   = q4 + 17'(i_s1.q400) - 17'(i_s1.q100);

        n_s2.dt    = i_s1.dt;
        n_s2.yy    = yr_mod[dnc_pkg::YY_W-1:0];
        n_s2.qy_lo = i_s1.qy[1:0];
        n_s2.n365  = 25'(i_s1.n) * dnc_pkg::DAYS_PER_YEAR;
        n_s2.qsum  = qsum[dnc_pkg::QSUM_W-1:0];
        n_s2.tod   = 17'(i_s1.dt.hour) * dnc_pkg::SECS_PER_HOUR
                   + 17'(i_s1.dt.minute) * dnc_pkg::SECS_PER_MIN
                   + 17'(i_s1.dt.second);
    end

    // Stage three
    always_comb begin
        y4    = (r_s2.dt.year[1:0] == 2'd0);
        leap  = y4 && ((r_s2.yy != '0) || (r_s2.qy_lo == 2'd0));
        early = (r_s2.dt.month < dnc_pkg::MONTH_MAR);

        n_s3.dt   = r_s2.dt;
        n_s3.tod  = r_s2.tod;
        n_s3.days = r_s2.n365
                  + 25'(r_s2.qsum)
                  + 25'(dnc_pkg::cum_days(r_s2.dt.month))
                  + 25'(leap && !early)
                  + 25'(r_s2.dt.day);
        n_s3.wsum = 8'(r_s2.yy) + 8'(r_s2.yy[dnc_pkg::YY_W-1:2])
                  + 8'(r_s2.dt.day) + 8'(dnc_pkg::month_code(r_s2.dt.month))
                  - 8'(y4 && early);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s2 <= n_s2;
        end
        if (i_en[1]) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

>>> design/dnc_secs.sv
// Fourth and fifth stages: day count to seconds, weekday reduction, final sum.
module dnc_secs (
    input  logic          i_clk,
    input  logic [1:0]    i_en,
    input  dnc_pkg::t_s3  i_s3,
    output dnc_pkg::t_s5  o_s5
);

    dnc_pkg::t_s4                  r_s4;
    dnc_pkg::t_s4                  n_s4;
    dnc_pkg::t_s5                  r_s5;
    dnc_pkg::t_s5                  n_s5;
    logic [dnc_pkg::DAYS_W+dnc_pkg::RECIP_W-1:0] day_secs;

    always_comb begin
        day_secs  = 42'(i_s3.days) * 42'(dnc_pkg::SECS_PER_DAY);
        n_s4.dt   = i_s3.dt;
        n_s4.tod  = i_s3.tod;
        n_s4.prod = day_secs[dnc_pkg::TOTAL_W-1:0];
        n_s4.wk   = dnc_pkg::mod7(i_s3.wsum);

        // Wrap to 32 bits
        n_s5.dt    = r_s4.dt;
        n_s5.wk    = r_s4.wk;
        n_s5.total = r_s4.prod + 32'(r_s4.tod);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s4 <= n_s4;
        end
        if (i_en[1]) begin
            r_s5 <= n_s5;
        end
    end

    assign o_s5 = r_s5;

endmodule

>>> design/datetime_normalize_convert.sv
// Top level of the date/time normalizer: five-stage pipeline and handshake control.
//
//  channel | valid    | ready    | word
//  --------+----------+----------+-------------------------------------------------
//  in      | i_valid  | o_ready  | i_raw_day/month/year/hour/minute/second
//  out     | o_valid  | i_ready  | o_day_out ... o_second_out, o_weekday,
//          |          |          | o_total_seconds
//
//  A word accepted on the input moves through stage registers one to five in turn; o_valid
//  rises once it reaches stage five. One word enters per cycle while o_ready is high.
//  The stage count is set by the 34-bit reciprocal products (stage one), the
//  whole-year day count (stages two and three) and the 86400 multiply (stage four).
//  Reset clears only the stage valid bits; payload registers hold garbage.
//  A stall on the output passes back combinationally to every full stage through the ready chain:
//  an empty stage still loads, so bubbles collapse and no word is lost or repeated.
module datetime_normalize_convert (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_raw_day,
    input  logic [7:0]                   i_raw_month,
    input  logic [15:0]                  i_raw_year,
    input  logic [7:0]                   i_raw_hour,
    input  logic [7:0]                   i_raw_minute,
    input  logic [7:0]                   i_raw_second,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [4:0]                   o_day_out,
    output logic [3:0]                   o_month_out,
    output logic [15:0]                  o_year_out,
    output logic [4:0]                   o_hour_out,
    output logic [5:0]                   o_minute_out,
    output logic [5:0]                   o_second_out,
    output logic [2:0]                   o_weekday,
    output logic [31:0]                  o_total_seconds
);

    localparam int NS = dnc_pkg::NUM_STAGES;

    logic [NS-1:0]   r_vld;
    logic [NS-1:0]   n_vld;
    logic [NS-1:0]   rdy;
    dnc_pkg::t_s1    s1;
    dnc_pkg::t_s3    s3;
    dnc_pkg::t_s5    s5;

    // Ready chain: a stage loads when empty or when the next one moves
    always_comb begin
        rdy[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld[0] = rdy[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NS; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Clamp fields, start the year quotients
    dnc_clamp u_clamp (
        .i_clk        (i_clk),
        .i_en         (rdy[0]),
        .i_raw_day    (i_raw_day),
        .i_raw_month  (i_raw_month),
        .i_raw_year   (i_raw_year),
        .i_raw_hour   (i_raw_hour),
        .i_raw_minute (i_raw_minute),
        .i_raw_second (i_raw_second),
        .o_s1         (s1)
    );

    // Day count and weekday sum
    dnc_days u_days (
        .i_clk (i_clk),
        .i_en  (rdy[2:1]),
        .i_s1  (s1),
        .o_s3  (s3)
    );

    // Seconds and weekday residue
    dnc_secs u_secs (
        .i_clk (i_clk),
        .i_en  (rdy[4:3]),
        .i_s3  (s3),
        .o_s5  (s5)
    );

    assign o_ready         = rdy[0];
    assign o_valid         = r_vld[NS-1];
    assign o_day_out       = s5.dt.day;
    assign o_month_out     = s5.dt.month;
    assign o_year_out      = s5.dt.year;
    assign o_hour_out      = s5.dt.hour;
    assign o_minute_out    = s5.dt.minute;
    assign o_second_out    = s5.dt.second;
    assign o_weekday       = s5.wk;
    assign o_total_seconds = s5.total;

    // Reset empties the pipeline
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid word out of a reset pipeline");

    // Weekday residue stays below seven
    a_weekday_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_weekday < 3'd7))
        else $error("weekday residue out of range");

    // Clamped date fields stay in range, day within its month outside February
    a_date_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_day_out != 5'd0) && (o_month_out != 4'd0) && (o_month_out <= 4'd12)
                    && (o_day_out <= dnc_pkg::month_len(o_month_out)
                        || o_month_out == dnc_pkg::MONTH_FEB))
        else $error("clamped date out of range");

    // A full pipeline with a stalled output takes no new word
    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_ready) |-> !o_ready)
        else $error("word taken into a full stalled pipeline");

endmodule

>>> test/dnc_checker.sv
// Checker for the date/time converter: watches both channels, predicts and compares words.
`timescale 1ns / 100ps

module dnc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [7:0]                    i_raw_day,
    input  logic [7:0]                    i_raw_month,
    input  logic [15:0]                   i_raw_year,
    input  logic [7:0]                    i_raw_hour,
    input  logic [7:0]                    i_raw_minute,
    input  logic [7:0]                    i_raw_second,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [dnc_pkg::DAY_W-1:0]     i_day_out,
    input  logic [dnc_pkg::MONTH_W-1:0]   i_month_out,
    input  logic [dnc_pkg::YEAR_W-1:0]    i_year_out,
    input  logic [dnc_pkg::HOUR_W-1:0]    i_hour_out,
    input  logic [dnc_pkg::MIN_W-1:0]     i_minute_out,
    input  logic [dnc_pkg::SEC_W-1:0]     i_second_out,
    input  logic [dnc_pkg::WK_W-1:0]      i_weekday,
    input  logic [dnc_pkg::TOTAL_W-1:0]   i_total_seconds,
    output int                            o_errors,
    output int                            o_pending
);

    typedef struct {
        logic [dnc_pkg::DAY_W-1:0]   day;
        logic [dnc_pkg::MONTH_W-1:0] month;
        logic [dnc_pkg::YEAR_W-1:0]  year;
        logic [dnc_pkg::HOUR_W-1:0]  hour;
        logic [dnc_pkg::MIN_W-1:0]   minute;
        logic [dnc_pkg::SEC_W-1:0]   second;
        logic [dnc_pkg::WK_W-1:0]    weekday;
        logic [dnc_pkg::TOTAL_W-1:0] total;
    } t_calendar_word;

    localparam int MONTH_DAYS[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int WEEK_CODE[12]  = '{6, 2, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

    t_calendar_word due_dates[$];
    int             err_count  = 0;
    int             pend_count = 0;

    assign o_errors  = err_count;
    assign o_pending = pend_count;

    function automatic t_calendar_word calendar_convert(
        input logic [7:0]  rd,
        input logic [7:0]  rm,
        input logic [15:0] ry,
        input logic [7:0]  rh,
        input logic [7:0]  rmi,
        input logic [7:0]  rs
    );
        t_calendar_word  w;
        int unsigned     d, m, y, h, mi, s, lim, yy, wk, n, k;
        longint unsigned days, total;
        d  = rd;
        m  = rm;
        y  = ry;
        h  = (rh > 23) ? 23 : rh;
        mi = (rmi > 59) ? 59 : rmi;
        s  = (rs > 59) ? 59 : rs;
        if (d < 1) d = 1;
        if (d > 31) d = 31;
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        // clamp uses the plain divisible-by-four rule for February
        if (m == dnc_pkg::MONTH_FEB) lim = (y % 4 != 0) ? 28 : 29;
        else lim = MONTH_DAYS[m-1];
        if (d > lim) d = lim;

        yy = y % 100;
        wk = yy + yy / 4 + d + WEEK_CODE[m-1];
        if ((y % 4 == 0) && (m < 3)) wk = wk - 1;
        wk = wk % 7;

        // whole years 0 .. year-2, then earlier months with the Gregorian rule
        n    = (y >= 1) ? y - 1 : 0;
        days = longint'(n) * 365 + (n + 3) / 4 - (n + 99) / 100 + (n + 399) / 400;
        for (k = 1; k < m; k++) begin
            if (k == dnc_pkg::MONTH_FEB)
                days += ((y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0))) ? 29 : 28;
            else
                days += MONTH_DAYS[k-1];
        end
        days += d;
        total = days * 86400 + h * 3600 + mi * 60 + s;

        w.day     = d[dnc_pkg::DAY_W-1:0];
        w.month   = m[dnc_pkg::MONTH_W-1:0];
        w.year    = ry;
        w.hour    = h[dnc_pkg::HOUR_W-1:0];
        w.minute  = mi[dnc_pkg::MIN_W-1:0];
        w.second  = s[dnc_pkg::SEC_W-1:0];
        w.weekday = wk[dnc_pkg::WK_W-1:0];
        w.total   = total[dnc_pkg::TOTAL_W-1:0];
        return w;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_calendar_word want;
        if (i_rst_n) begin
            // retire the oldest word first; a word entering now cannot leave now
            if (i_out_valid && i_out_ready) begin
                if (due_dates.size() == 0) begin
                    $error("result word with nothing expected");
                    err_count++;
                end else begin
                    want = due_dates.pop_front();
                    check_field("day_out",       want.day,     i_day_out);
                    check_field("month_out",     want.month,   i_month_out);
                    check_field("year_out",      want.year,    i_year_out);
                    check_field("hour_out",      want.hour,    i_hour_out);
                    check_field("minute_out",    want.minute,  i_minute_out);
                    check_field("second_out",    want.second,  i_second_out);
                    check_field("weekday",       want.weekday, i_weekday);
                    check_field("total_seconds", want.total,   i_total_seconds);
                end
            end
            if (i_in_valid && i_in_ready) begin
                due_dates.push_back(calendar_convert(i_raw_day, i_raw_month, i_raw_year,
                                                     i_raw_hour, i_raw_minute, i_raw_second));
            end
            pend_count <= due_dates.size();
        end
    end

endmodule

>>> test/tb.sv
// Testbench top for the date/time converter: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb;

    // Cycles with no word moving on either channel before the run is declared hung.
    // The limit stays above the long receiver hold-off, HOLD_CYCLES, and every sender gap.
    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_WORDS = 1280;
    localparam int HOLD_CYCLES  = 300;

    typedef enum int {RX_FREE, RX_COIN, RX_SLOW, RX_PERIODIC} t_rx_mode;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [7:0]                   i_raw_day;
    logic [7:0]                   i_raw_month;
    logic [15:0]                  i_raw_year;
    logic [7:0]                   i_raw_hour;
    logic [7:0]                   i_raw_minute;
    logic [7:0]                   i_raw_second;
    logic                         o_valid;
    logic                         i_ready;
    logic [dnc_pkg::DAY_W-1:0]    o_day_out;
    logic [dnc_pkg::MONTH_W-1:0]  o_month_out;
    logic [dnc_pkg::YEAR_W-1:0]   o_year_out;
    logic [dnc_pkg::HOUR_W-1:0]   o_hour_out;
    logic [dnc_pkg::MIN_W-1:0]    o_minute_out;
    logic [dnc_pkg::SEC_W-1:0]    o_second_out;
    logic [dnc_pkg::WK_W-1:0]     o_weekday;
    logic [dnc_pkg::TOTAL_W-1:0]  o_total_seconds;

    int errors;
    int pending;
    int idle_cycles = 0;

    datetime_normalize_convert u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_raw_day       (i_raw_day),
        .i_raw_month     (i_raw_month),
        .i_raw_year      (i_raw_year),
        .i_raw_hour      (i_raw_hour),
        .i_raw_minute    (i_raw_minute),
        .i_raw_second    (i_raw_second),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_day_out       (o_day_out),
        .o_month_out     (o_month_out),
        .o_year_out      (o_year_out),
        .o_hour_out      (o_hour_out),
        .o_minute_out    (o_minute_out),
        .o_second_out    (o_second_out),
        .o_weekday       (o_weekday),
        .o_total_seconds (o_total_seconds)
    );

    dnc_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_raw_day       (i_raw_day),
        .i_raw_month     (i_raw_month),
        .i_raw_year      (i_raw_year),
        .i_raw_hour      (i_raw_hour),
        .i_raw_minute    (i_raw_minute),
        .i_raw_second    (i_raw_second),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_day_out       (o_day_out),
        .i_month_out     (o_month_out),
        .i_year_out      (o_year_out),
        .i_hour_out      (o_hour_out),
        .i_minute_out    (o_minute_out),
        .i_second_out    (o_second_out),
        .i_weekday       (o_weekday),
        .i_total_seconds (o_total_seconds),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hung-run guard: count cycles in which no word moves on either channel.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Receiver: switch between stall patterns at random intervals, and twice
    // hold ready low for a long stretch so the pipeline fills and o_ready drops
    // while the sender keeps offering words.
    initial begin : receiver
        t_rx_mode mode;
        int       cyc;
        int       mode_left;
        int       hold_left;
        i_ready   = 1'b0;
        mode      = RX_FREE;
        cyc       = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == 600 || cyc == 1800) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(40, 200);
                end
                mode_left--;
                case (mode)
                    RX_FREE:  i_ready <= 1'b1;
                    RX_COIN:  i_ready <= 1'($urandom_range(0, 1));
                    RX_SLOW:  i_ready <= ($urandom_range(0, 3) == 0);
                    default:  i_ready <= (cyc % 6 != 0);
                endcase
            end
        end
    end

    // Offer one word and hold it until accepted. Called at a rising edge; returns
    // at the edge that took the word, with i_valid still high.
    task automatic offer(
        input logic [7:0]  d,
        input logic [7:0]  m,
        input logic [15:0] y,
        input logic [7:0]  h,
        input logic [7:0]  mi,
        input logic [7:0]  s
    );
        i_valid      <= 1'b1;
        i_raw_day    <= d;
        i_raw_month  <= m;
        i_raw_year   <= y;
        i_raw_hour   <= h;
        i_raw_minute <= mi;
        i_raw_second <= s;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin : stimulus
        int          burst_left;
        int          gap;
        int          kind;
        logic [7:0]  d, m, h, mi, s;
        logic [15:0] y;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_raw_day    = '0;
        i_raw_month  = '0;
        i_raw_year   = '0;
        i_raw_hour   = '0;
        i_raw_minute = '0;
        i_raw_second = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all-zero raw word (day and month forced to 1, year zero)
        offer(8'd0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0);
        // all-ones raw word: every field saturates, seconds count wraps
        offer(8'd255, 8'd255, 16'd65535, 8'd255, 8'd255, 8'd255);
        // year one and year two: no or one whole year counted
        offer(8'd31, 8'd12, 16'd1, 8'd23, 8'd59, 8'd59);
        offer(8'd1, 8'd1, 16'd2, 8'd0, 8'd0, 8'd1);
        // Feb 29 kept in century years: 1900 is not a Gregorian leap year, 2000 is
        offer(8'd29, 8'd2, 16'd1900, 8'd12, 8'd30, 8'd45);
        offer(8'd29, 8'd2, 16'd2000, 8'd6, 8'd7, 8'd8);
        // Feb clamped to 28 in a year not divisible by four
        offer(8'd31, 8'd2, 16'd2001, 8'd1, 8'd2, 8'd3);
        // January of a leap year: weekday takes the minus one
        offer(8'd1, 8'd1, 16'd2024, 8'd0, 8'd0, 8'd0);
        // hour, minute and second one past the limit
        offer(8'd10, 8'd3, 16'd2100, 8'd24, 8'd60, 8'd60);
        // day 32, month 13
        offer(8'd32, 8'd13, 16'd400, 8'd22, 8'd58, 8'd58);
        // zero day in a 30-day month
        offer(8'd0, 8'd4, 16'd1970, 8'd0, 8'd0, 8'd0);
        // largest year with a legal date
        offer(8'd31, 8'd12, 16'd65535, 8'd23, 8'd59, 8'd59);
        // day 31 in every month: covers each month code and each month length
        for (int k = 1; k <= 12; k++) begin
            offer(8'd31, 8'(k), 16'(1996 + k), 8'(k), 8'(k * 4), 8'(k * 5));
        end

        // Random: mostly legal dates, some near the clamp edges, some raw noise.
        burst_left = 0;
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                d  = 8'($urandom_range(1, 31));
                m  = 8'($urandom_range(1, 12));
                y  = $urandom_range(0, 1) ? 16'($urandom_range(1890, 2110)) : 16'($urandom);
                h  = 8'($urandom_range(0, 23));
                mi = 8'($urandom_range(0, 59));
                s  = 8'($urandom_range(0, 59));
            end else if (kind <= 7) begin
                d  = $urandom_range(0, 1) ? 8'($urandom_range(27, 33)) : 8'($urandom_range(0, 2));
                m  = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(11, 14));
                y  = $urandom_range(0, 1)
                   ? 16'($urandom_range(0, 5))
                   : 16'($urandom_range(0, 163) * 400 + $urandom_range(0, 4));
                h  = 8'($urandom_range(22, 25));
                mi = 8'($urandom_range(58, 61));
                s  = 8'($urandom_range(58, 61));
            end else begin
                d  = 8'($urandom);
                m  = 8'($urandom);
                y  = 16'($urandom);
                h  = 8'($urandom);
                mi = 8'($urandom);
                s  = 8'($urandom);
            end
            offer(d, m, y, h, mi, s);
        end
        i_valid <= 1'b0;

        // Drain: wait for every predicted word, then wait on so that a stray extra
        // word would still show up.
        do @(posedge i_clk); while (pending != 0);
        repeat (dnc_pkg::NUM_STAGES * 4) @(posedge i_clk);

        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

>>> files.f
design/dnc_pkg.sv
design/dnc_clamp.sv
design/dnc_days.sv
design/dnc_secs.sv
design/datetime_normalize_convert.sv
test/dnc_checker.sv
test/tb.sv
